// ----- rtl/esc_pkg.sv -----
// Shared constants and types for the environmental sensor compensation block.
`timescale 1ns / 1ps
package esc_pkg;

    // Conversion codes carried in op and kind
    localparam logic [1:0] OP_TEMP  = 2'd0;
    localparam logic [1:0] OP_PRESS = 2'd1;
    localparam logic [1:0] OP_HUM   = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Calibration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIXED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM     = 3'd4;

    // Job queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One classified job
    typedef struct packed {
        logic [1:0]  kind;
        logic        known;
        logic [19:0] raw;
    } t_job;

    // Arithmetic unit request and response
    typedef struct packed {
        logic start;
        logic div;
    } t_ar_req;

    typedef struct packed {
        logic done;
    } t_ar_rsp;

endpackage

// ----- rtl/esc_if.sv -----
// Handshake channel interfaces: sample input, result output, calibration writes.
`timescale 1ns / 1ps
interface esc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [19:0] raw_sample;
    modport source (output valid, op, raw_sample, input ready);
    modport sink   (input valid, op, raw_sample, output ready);
endinterface

interface esc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [32:0] value;
    logic               div_zero;
    modport source (output valid, kind, value, div_zero, input ready);
    modport sink   (input valid, kind, value, div_zero, output ready);
endinterface

interface esc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/esc_front.sv -----
// Front end: takes sample words, classifies the op and hands jobs to the queue.
`timescale 1ns / 1ps
module esc_front (
    esc_in_if.sink       i_in,
    input  logic         i_full,
    output logic         o_push,
    output esc_pkg::t_job o_job
);
    import esc_pkg::*;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Humidity uses only the low 16 bits of the sample
    always_comb begin
        o_job.kind  = i_in.op;
        o_job.known = (i_in.op != OP_NONE);
        o_job.raw   = (i_in.op == OP_HUM) ? {4'd0, i_in.raw_sample[15:0]} : i_in.raw_sample;
    end
endmodule

// ----- rtl/esc_queue.sv -----
// Small job queue decoupling the front end from the compute engine.
`timescale 1ns / 1ps
module esc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  esc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output esc_pkg::t_job o_job
);
    import esc_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ----- rtl/esc_arith.sv -----
// Shared arithmetic unit: 64-bit wrapping multiply and signed 64-bit divide.
`timescale 1ns / 1ps
module esc_arith (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  esc_pkg::t_ar_req i_req,
    input  logic [63:0]     i_a,
    input  logic [63:0]     i_b,
    output esc_pkg::t_ar_rsp o_rsp,
    output logic [63:0]     o_res
);
    import esc_pkg::*;

    typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV, A_FIX} t_astate;

    localparam logic [5:0] MUL_LAST = 6'd2;
    localparam logic [5:0] DIV_LAST = 6'd63;

    t_astate     r_state;
    logic [5:0]  r_cnt;
    logic [63:0] r_opa;
    logic [63:0] r_opb;
    logic [63:0] r_acc;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic        r_neg;
    logic        r_done;

    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [63:0] pp;
    logic [64:0] rem_sh;
    logic [64:0] dif;
    logic        ge;
    logic [63:0] abs_a;
    logic [63:0] abs_b;

    // One 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo
    assign m_a = (r_cnt == MUL_LAST) ? r_opa[63:32] : r_opa[31:0];
    assign m_b = (r_cnt == 6'd1) ? r_opb[63:32] : r_opb[31:0];
    assign pp  = m_a * m_b;

    // Restoring divide on magnitudes, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[63]};
    assign dif    = rem_sh - {1'b0, r_den};
    assign ge     = !dif[64];
    assign abs_a  = i_a[63] ? (~i_a + 64'd1) : i_a;
    assign abs_b  = i_b[63] ? (~i_b + 64'd1) : i_b;

    assign o_rsp.done = r_done;
    assign o_res      = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                A_IDLE: begin
                    r_done <= 1'b0;
                    if (i_req.start) begin
                        r_cnt <= '0;
                        if (i_req.div) begin
                            r_neg   <= i_a[63] ^ i_b[63];
                            r_quo   <= abs_a;
                            r_den   <= abs_b;
                            r_rem   <= '0;
                            r_state <= A_DIV;
                        end else begin
                            r_opa   <= i_a;
                            r_opb   <= i_b;
                            r_state <= A_MUL;
                        end
                    end
                end
                A_MUL: begin
                    r_acc  <= (r_cnt == '0) ? pp : r_acc + {pp[31:0], 32'd0};
                    r_cnt  <= r_cnt + 6'd1;
                    r_done <= (r_cnt == MUL_LAST);
                    if (r_cnt == MUL_LAST) begin
                        r_state <= A_IDLE;
                    end
                end
                A_DIV: begin
                    r_done <= 1'b0;
                    r_rem  <= ge ? dif[63:0] : rem_sh[63:0];
                    r_quo  <= {r_quo[62:0], ge};
                    r_cnt  <= r_cnt + 6'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= A_FIX;
                    end
                end
                A_FIX: begin
                    // Sign fix; most negative over minus one wraps naturally
                    r_acc   <= r_neg ? (~r_quo + 64'd1) : r_quo;
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= A_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/esc_back.sv -----
// Compute engine: calibration registers, step sequencer and result register.
`timescale 1ns / 1ps
module esc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    esc_cfg_if.sink          i_cfg,
    input  logic             i_job_valid,
    input  esc_pkg::t_job    i_job,
    output logic             o_job_pop,
    output esc_pkg::t_ar_req o_ar_req,
    output logic [63:0]      o_ar_a,
    output logic [63:0]      o_ar_b,
    input  esc_pkg::t_ar_rsp i_ar_rsp,
    input  logic [63:0]      i_ar_res,
    esc_out_if.source        o_out
);
    import esc_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_ISSUE, B_WAIT, B_POST, B_OUT} t_bstate;

    t_bstate            r_state;
    logic [1:0]         r_kind;
    logic [19:0]        r_raw;
    logic [3:0]         r_step;
    logic signed [63:0] r_a;
    logic signed [63:0] r_b;
    logic signed [63:0] r_c;
    logic signed [63:0] r_x;
    logic signed [31:0] r_fine;
    logic [47:0]        r_ct;
    logic [63:0]        r_pa;
    logic [63:0]        r_pb;
    logic [47:0]        r_pm;
    logic [39:0]        r_ph;
    logic signed [32:0] r_val;
    logic               r_dz;
    logic               r_ov;
    logic [1:0]         r_okind;
    logic signed [32:0] r_oval;
    logic               r_odz;

    logic signed [63:0] adc, fine64, fa, hv, pr;
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] h1, h2, h3, h4, h5, h6;
    logic signed [63:0] op_a, op_b, dt, ps;
    logic               op_div;
    logic signed [63:0] n_a, n_b, n_c, n_x, fin_v, hum_v;
    logic signed [31:0] n_fine;
    logic               fin, fin_dz;
    logic               out_load;

    function automatic logic signed [32:0] sat33(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v;
        if (v > 64'sd4294967295) s = 64'sd4294967295;
        if (v < -64'sd4294967296) s = -64'sd4294967296;
        return s[32:0];
    endfunction

    // Coefficient fields
    assign t1 = $signed({48'd0, r_ct[15:0]});
    assign t2 = $signed({{48{r_ct[31]}}, r_ct[31:16]});
    assign t3 = $signed({{48{r_ct[47]}}, r_ct[47:32]});
    assign p1 = $signed({48'd0, r_pa[15:0]});
    assign p2 = $signed({{48{r_pa[31]}}, r_pa[31:16]});
    assign p3 = $signed({{48{r_pa[47]}}, r_pa[47:32]});
    assign p4 = $signed({{48{r_pa[63]}}, r_pa[63:48]});
    assign p5 = $signed({{48{r_pb[15]}}, r_pb[15:0]});
    assign p6 = $signed({{48{r_pb[31]}}, r_pb[31:16]});
    assign p7 = $signed({{48{r_pb[47]}}, r_pb[47:32]});
    assign p8 = $signed({{48{r_pb[63]}}, r_pb[63:48]});
    assign p9 = $signed({{48{r_pm[15]}}, r_pm[15:0]});
    assign h1 = $signed({56'd0, r_pm[23:16]});
    assign h2 = $signed({{48{r_pm[39]}}, r_pm[39:24]});
    assign h3 = $signed({56'd0, r_pm[47:40]});
    assign h4 = $signed({{48{r_ph[15]}}, r_ph[15:0]});
    assign h5 = $signed({{48{r_ph[31]}}, r_ph[31:16]});
    assign h6 = $signed({{56{r_ph[39]}}, r_ph[39:32]});

    assign adc    = $signed({44'd0, r_raw});
    assign fine64 = $signed({{32{r_fine[31]}}, r_fine});
    assign fa     = fine64 - 64'sd128000;
    assign hv     = fine64 - 64'sd76800;
    assign pr     = $signed(i_ar_res);
    assign dt     = (adc >>> 4) - t1;
    assign ps     = r_c >>> 13;

    // Operands of the current step
    always_comb begin
        op_a   = fa;
        op_b   = fa;
        op_div = 1'b0;
        case (r_kind)
            OP_TEMP: begin
                case (r_step)
                    4'd0:    begin op_a = (adc >>> 3) - (t1 <<< 1); op_b = t2; end
                    4'd1:    begin op_a = dt; op_b = dt; end
                    4'd2:    begin op_a = r_b; op_b = t3; end
                    default: begin op_a = r_a; op_b = 64'sd5; end
                endcase
            end
            OP_PRESS: begin
                case (r_step)
                    4'd0:    begin op_a = fa; op_b = fa; end
                    4'd1:    begin op_a = r_c; op_b = p6; end
                    4'd2:    begin op_a = fa; op_b = p5; end
                    4'd3:    begin op_a = r_c; op_b = p3; end
                    4'd4:    begin op_a = fa; op_b = p2; end
                    4'd5:    begin op_a = r_a; op_b = p1; end
                    4'd6:    begin
                        op_a = ((64'sd1048576 - adc) <<< 31) - r_b;
                        op_b = 64'sd3125;
                    end
                    4'd7:    begin op_a = r_x; op_b = r_a; op_div = 1'b1; end
                    4'd8:    begin op_a = p9; op_b = ps; end
                    4'd9:    begin op_a = r_x; op_b = ps; end
                    default: begin op_a = p8; op_b = r_c; end
                endcase
            end
            default: begin
                case (r_step)
                    4'd0:    begin op_a = h5; op_b = hv; end
                    4'd1:    begin op_a = hv; op_b = h3; end
                    4'd2:    begin op_a = hv; op_b = h6; end
                    4'd3:    begin op_a = r_a; op_b = r_b; end
                    4'd4:    begin op_a = r_b + 64'sd2097152; op_b = h2; end
                    4'd5:    begin op_a = r_x; op_b = r_b; end
                    4'd6:    begin op_a = r_c >>> 15; op_b = r_c >>> 15; end
                    default: begin op_a = r_a; op_b = h1; end
                endcase
            end
        endcase
    end

    // Result handling of the current step
    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_c    = r_c;
        n_x    = r_x;
        n_fine = r_fine;
        fin    = 1'b0;
        fin_v  = 64'sd0;
        fin_dz = 1'b0;
        hum_v  = r_c - ((pr >>> 4));
        case (r_kind)
            OP_TEMP: begin
                case (r_step)
                    4'd0: n_a = pr >>> 11;
                    4'd1: n_b = pr >>> 12;
                    4'd2: begin
                        n_a    = r_a + (pr >>> 14);
                        n_fine = n_a[31:0];
                    end
                    default: begin
                        fin   = 1'b1;
                        fin_v = (pr + 64'sd128) >>> 8;
                    end
                endcase
            end
            OP_PRESS: begin
                case (r_step)
                    4'd0: n_c = pr;
                    4'd1: n_b = pr;
                    4'd2: n_b = r_b + (pr <<< 17) + (p4 <<< 35);
                    4'd3: n_x = pr >>> 8;
                    4'd4: n_a = r_x + (pr <<< 12) + (64'sd1 <<< 47);
                    4'd5: begin
                        n_a = pr >>> 33;
                        if (n_a == 64'sd0) begin
                            fin    = 1'b1;
                            fin_dz = 1'b1;
                        end
                    end
                    4'd6: n_x = pr;
                    4'd7: n_c = pr;
                    4'd8: n_x = pr;
                    4'd9: n_a = pr >>> 25;
                    default: begin
                        fin   = 1'b1;
                        fin_v = ((r_c + r_a + (pr >>> 19)) >>> 8) + (p7 <<< 4);
                    end
                endcase
            end
            default: begin
                case (r_step)
                    4'd0: n_x = ((adc <<< 14) - (h4 <<< 20) - pr + 64'sd16384) >>> 15;
                    4'd1: n_b = (pr >>> 11) + 64'sd32768;
                    4'd2: n_a = pr >>> 10;
                    4'd3: n_b = pr >>> 10;
                    4'd4: n_b = (pr + 64'sd8192) >>> 14;
                    4'd5: n_c = pr;
                    4'd6: n_a = pr >>> 7;
                    default: begin
                        fin = 1'b1;
                        if (hum_v < 64'sd0) hum_v = 64'sd0;
                        if (hum_v > 64'sd419430400) hum_v = 64'sd419430400;
                        fin_v = hum_v >>> 12;
                    end
                endcase
            end
        endcase
    end

    // Output register loads when empty or being drained this cycle
    assign out_load       = (r_state == B_OUT) && (!r_ov || o_out.ready);

    assign o_job_pop      = (r_state == B_IDLE);
    assign o_ar_req.start = (r_state == B_ISSUE);
    assign o_ar_req.div   = op_div;
    assign o_ar_a         = op_a;
    assign o_ar_b         = op_b;
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_ov;
    assign o_out.kind     = r_okind;
    assign o_out.value    = r_oval;
    assign o_out.div_zero = r_odz;

    // Sequencer, calibration registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
            r_fine  <= '0;
            r_ct    <= '0;
            r_pa    <= '0;
            r_pb    <= '0;
            r_pm    <= '0;
            r_ph    <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_TEMP:    r_ct <= i_cfg.data[47:0];
                    CFG_PRESS_A: r_pa <= i_cfg.data;
                    CFG_PRESS_B: r_pb <= i_cfg.data;
                    CFG_MIXED:   r_pm <= i_cfg.data[47:0];
                    CFG_HUM:     r_ph <= i_cfg.data[39:0];
                    default:     ;
                endcase
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_kind <= i_job.kind;
                        r_raw  <= i_job.raw;
                        r_step <= '0;
                        if (i_job.known) begin
                            r_state <= B_ISSUE;
                        end else begin
                            r_val   <= '0;
                            r_dz    <= 1'b0;
                            r_state <= B_OUT;
                        end
                    end
                end
                B_ISSUE: r_state <= B_WAIT;
                B_WAIT: begin
                    if (i_ar_rsp.done) begin
                        r_state <= B_POST;
                    end
                end
                B_POST: begin
                    r_a    <= n_a;
                    r_b    <= n_b;
                    r_c    <= n_c;
                    r_x    <= n_x;
                    r_fine <= n_fine;
                    if (fin) begin
                        r_val   <= sat33(fin_v);
                        r_dz    <= fin_dz;
                        r_state <= B_OUT;
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_state <= B_ISSUE;
                    end
                end
                B_OUT: begin
                    if (out_load) begin
                        r_okind <= r_kind;
                        r_oval  <= r_val;
                        r_odz   <= r_dz;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_dz_only_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_odz |-> r_okind == OP_PRESS)
        else $error("div_zero flag on a non-pressure word");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_okind == OP_NONE |-> r_oval == '0 && !r_odz)
        else $error("unused op produced a nonzero word");
    a_fine_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_fine) |-> $past(r_kind) == OP_TEMP)
        else $error("fine temperature changed outside a temperature job");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_POST |-> r_step <= 4'd10)
        else $error("step counter ran past the pressure sequence");
`endif
endmodule

// ----- rtl/env_sensor_compensation_top.sv -----
// Top level of the environmental sensor compensation block.
//
//  channel  | dir | payload                         | accepted when
//  i_in     | in  | op, raw_sample                  | valid && ready
//  o_out    | out | kind, value, div_zero           | valid && ready
//  i_cfg    | in  | index, data (calibration word)  | valid && ready (ready tied high)
//
//  Each conversion runs as a sequence of steps, and each step uses the shared arithmetic unit (a
//  64-bit multiply is built from three 32x32 partial products, and the divide is bit-serial)
//  plus the issue and post states of the sequencer.
//  Synchronous active-low reset clears control state, calibration and the fine temperature.
//  A two-entry job queue takes words while the engine works or the output stalls, until it is full.
`timescale 1ns / 1ps
module env_sensor_compensation_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esc_in_if.sink    i_in,
    esc_cfg_if.sink   i_cfg,
    esc_out_if.source o_out
);
    import esc_pkg::*;

    logic        push, full, pop, q_valid;
    t_job        f_job, q_job;
    t_ar_req     ar_req;
    t_ar_rsp     ar_rsp;
    logic [63:0] ar_a, ar_b, ar_res;

    esc_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_job  (f_job)
    );

    esc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    esc_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ar_req),
        .i_a     (ar_a),
        .i_b     (ar_b),
        .o_rsp   (ar_rsp),
        .o_res   (ar_res)
    );

    esc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (pop),
        .o_ar_req    (ar_req),
        .o_ar_a      (ar_a),
        .o_ar_b      (ar_b),
        .i_ar_rsp    (ar_rsp),
        .i_ar_res    (ar_res),
        .o_out       (o_out)
    );
endmodule
